// ===== design/epd_pkg.sv =====
// ----------------------------------------------------------------------------
// epd_pkg
// Shared constants, result type and packing helper for the EEG packet deframer.
// ----------------------------------------------------------------------------
package epd_pkg;

  localparam int unsigned POS_W = 5;

  localparam logic [7:0] SYNC_FIRST   = 8'hA5;
  localparam logic [7:0] SYNC_SECOND  = 8'h5A;
  localparam logic [7:0] VERSION_CODE = 8'h02;
  localparam logic [3:0] BUTTON_MASK  = 4'hF;

  localparam logic [POS_W-1:0] POS_SYNC_FIRST  = 5'd0;
  localparam logic [POS_W-1:0] POS_SYNC_SECOND = 5'd1;
  localparam logic [POS_W-1:0] POS_VERSION     = 5'd2;
  localparam logic [POS_W-1:0] POS_FRAME       = 5'd3;
  localparam logic [POS_W-1:0] POS_CHAN_BASE   = 5'd4;
  localparam logic [POS_W-1:0] POS_BUTTON      = 5'd16;

  localparam int unsigned CHANNEL_COUNT = 6;
  // Store keeps packet bytes from the version byte up to the last channel byte.
  localparam int unsigned STORE_LO = 2;
  localparam int unsigned STORE_HI = 15;

  localparam int unsigned OUT_BITS  = 8 + 8 + 16 * CHANNEL_COUNT + 4;
  localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;
  localparam int unsigned OUT_W     = OUT_BYTES * 8;

  typedef struct packed {
    logic [3:0]                       buttons;
    logic [CHANNEL_COUNT-1:0][15:0]   channel;   // [0] is channel one
    logic [7:0]                       frame_count;
    logic [7:0]                       version;
  } epd_result_t;

  // Pack fields from the lowest bit up, zero filled to whole bytes.
  function automatic logic [OUT_W-1:0] epd_pack(input epd_result_t r);
    logic [OUT_W-1:0] d;
    d = '0;
    d[7:0]  = r.version;
    d[15:8] = r.frame_count;
    for (int k = 0; k < CHANNEL_COUNT; k++) begin
      d[16 + 16*k +: 16] = r.channel[k];
    end
    d[16 + 16*CHANNEL_COUNT +: 4] = r.buttons;
    return d;
  endfunction

endpackage

// ===== design/epd_parser.sv =====
// ----------------------------------------------------------------------------
// epd_parser
// Byte position tracker and packet byte store; builds the result on the
// button byte.
// ----------------------------------------------------------------------------
module epd_parser
  import epd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_ok,     // byte accepted this cycle
  input  logic [7:0]  rx_byte,
  output logic        at_last,     // next byte is the button byte
  output logic        pkt_done,    // result valid this cycle (with byte_ok)
  output epd_result_t pkt_result
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] pos_eff;
  logic [7:0]       store_r [STORE_LO:STORE_HI];
  logic             bad_hdr;

  always_comb begin
    pos_eff = (pos_r > POS_BUTTON) ? POS_SYNC_FIRST : pos_r;
    bad_hdr = ((pos_eff == POS_SYNC_FIRST)  && (rx_byte != SYNC_FIRST))  ||
              ((pos_eff == POS_SYNC_SECOND) && (rx_byte != SYNC_SECOND)) ||
              ((pos_eff == POS_VERSION)     && (rx_byte != VERSION_CODE));
    if (bad_hdr || pos_eff == POS_BUTTON) begin
      pos_nxt = POS_SYNC_FIRST;
    end else begin
      pos_nxt = pos_eff + 5'd1;
    end
  end

  assign at_last  = (pos_eff == POS_BUTTON);
  assign pkt_done = byte_ok && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_SYNC_FIRST;
    end else if (byte_ok) begin
      pos_r <= pos_nxt;
    end
  end

  // Header and sync bytes at positions 0 and 1 need no storage.
  always_ff @(posedge clk) begin
    if (byte_ok && !bad_hdr && pos_eff >= POS_VERSION && pos_eff < POS_BUTTON) begin
      store_r[pos_eff[3:0]] <= rx_byte;
    end
  end

  always_comb begin
    pkt_result.version     = store_r[POS_VERSION[3:0]];
    pkt_result.frame_count = store_r[POS_FRAME[3:0]];
    for (int k = 0; k < CHANNEL_COUNT; k++) begin
      pkt_result.channel[k] = {store_r[POS_CHAN_BASE[3:0] + 4'(2*k)],
                               store_r[POS_CHAN_BASE[3:0] + 4'(2*k + 1)]};
    end
    pkt_result.buttons = rx_byte[3:0] & BUTTON_MASK;
  end

endmodule

// ===== design/epd_out_reg.sv =====
// ----------------------------------------------------------------------------
// epd_out_reg
// Result register on the master side; holds a beat until it is taken.
// ----------------------------------------------------------------------------
module epd_out_reg
  import epd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  epd_result_t      result,
  output logic             can_load,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  logic             valid_r;
  logic [OUT_W-1:0] data_r;

  assign can_load   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= epd_pack(result);
    end
  end

endmodule

// ===== design/eeg_packet_deframer.sv =====
// A packet result appears on out_tvalid in the cycle after its button byte is accepted.
// Throughput: one byte per cycle while in_tready is high; the position counter updates on each accepted byte.
// Only the button byte waits for the result register to be free; other bytes pass
// while a result is pending.
// Reset (rst_n low, synchronous): parser looks for the first sync byte, no result held.
// ----------------------------------------------------------------------------
// eeg_packet_deframer
// Assembles 17-byte sensor packets from a byte stream and emits one decoded
// result beat per complete packet.
// ----------------------------------------------------------------------------
module eeg_packet_deframer
  import epd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  logic             out_tready,
  // [7:0] version, [15:8] frame_count, [31:16] channel_one, [47:32] channel_two,
  // [63:48] channel_three, [79:64] channel_four, [95:80] channel_five,
  // [111:96] channel_six, [115:112] buttons, [119:116] zero
  output logic [OUT_W-1:0] out_tdata
);

  logic        at_last;
  logic        can_load;
  logic        byte_ok;
  logic        pkt_done;
  epd_result_t pkt_result;

  assign in_tready = !at_last || can_load;
  assign byte_ok   = in_tvalid && in_tready;

  epd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_ok    (byte_ok),
    .rx_byte    (in_tdata),
    .at_last    (at_last),
    .pkt_done   (pkt_done),
    .pkt_result (pkt_result)
  );

  epd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (pkt_done),
    .result     (pkt_result),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
